@@ rtl/kts_pkg.sv @@
// shared types and constants for the keyframe track sampler
`default_nettype none
package kts_pkg;
  localparam int unsigned TW = 32;
  localparam int unsigned SLOT_W = 6;
  localparam int unsigned CNT_W = 7;
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // command handed from front to back
  typedef struct packed {
    logic              op;
    logic [SLOT_W-1:0] slot;
    logic [TW-1:0]     t;
    logic [TW-1:0]     x;
    logic [TW-1:0]     y;
    logic [TW-1:0]     z;
  } kts_cmd_t;
endpackage
`default_nettype wire

@@ rtl/kts_front.sv @@
// input stage: two-entry command queue between input channel and engine
`default_nettype none
module kts_front (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire kts_pkg::kts_cmd_t in_cmd,
  output logic              cmd_valid,
  input  wire logic         cmd_ready,
  output kts_pkg::kts_cmd_t cmd
);
  import kts_pkg::*;

  kts_cmd_t  q [2];
  logic      wp;
  logic      rp;
  logic [1:0] count;
  logic      push;
  logic      pop;

  assign in_ready  = (count != 2'd2);
  assign cmd_valid = (count != 2'd0);
  assign cmd       = q[rp];
  assign push      = in_valid & in_ready;
  assign pop       = cmd_valid & cmd_ready;

  // queue storage
  always_ff @(posedge clk) begin
    if (push) q[wp] <= in_cmd;
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

`ifndef SYNTH
  a_no_over: assert property (@(posedge clk) disable iff (rst)
    count == 2'd2 |-> !in_ready) else $error("queue overfilled");
  a_count_ok: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3) else $error("bad count");
  a_step: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count != 2'd0) else $error("lost push");
`endif
endmodule
`default_nettype wire

@@ rtl/kts_back.sv @@
// engine: key store, segment scan, divider, blend and output register
`default_nettype none
module kts_back #(
  parameter int unsigned MAX_KEYS = 64
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic [kts_pkg::CNT_W-1:0] keys_in_use,
  input  wire logic                 cmd_valid,
  output logic                      cmd_ready,
  input  wire kts_pkg::kts_cmd_t    cmd,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [31:0]               out_x,
  output logic [31:0]               out_y,
  output logic [31:0]               out_z
);
  import kts_pkg::*;

  localparam int unsigned AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_RD0   = 9'b000000010,
    S_CHK0  = 9'b000000100,
    S_RDA   = 9'b000001000,
    S_CHKA  = 9'b000010000,
    S_DIV   = 9'b000100000,
    S_MUL   = 9'b001000000,
    S_ADD   = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  state_t state;
  logic [TW-1:0] tmem [MAX_KEYS];
  logic [TW-1:0] xmem [MAX_KEYS];
  logic [TW-1:0] ymem [MAX_KEYS];
  logic [TW-1:0] zmem [MAX_KEYS];
  logic [TW-1:0] trd, xrd, yrd, zrd;
  logic [AW-1:0] raddr;
  logic [AW-1:0] waddr;
  logic          we;

  logic signed [TW-1:0] st;
  logic [AW:0]   nkeys;
  logic [AW:0]   idx;
  logic signed [TW-1:0] t0;
  logic [TW-1:0] ax, ay, az;
  logic [TW:0]   num;
  logic [TW:0]   den;
  logic [TW+16:0] rem;
  logic [15:0]   frac;
  logic [4:0]    dcnt;
  logic signed [TW:0] dx, dy, dz;
  logic signed [TW+17:0] px, py, pz;
  logic [1:0]    mstep;

  logic [AW:0] n_raw;

  // clamp key count to [1, MAX_KEYS]
  always_comb begin
    if (keys_in_use == '0) n_raw = (AW+1)'(1);
    else if ({{(AW+1){1'b0}}, keys_in_use} > (AW+CNT_W+1)'(MAX_KEYS))
      n_raw = (AW+1)'(MAX_KEYS);
    else n_raw = (AW+1)'(keys_in_use);
  end

  assign cmd_ready = (state == S_IDLE);
  assign we = cmd_valid && cmd_ready && (cmd.op == OP_WRITE) &&
              ({{AW{1'b0}}, cmd.slot} < (AW+SLOT_W)'(MAX_KEYS));
  assign waddr = AW'(cmd.slot);

  // key store
  always_ff @(posedge clk) begin
    if (we) begin
      tmem[waddr] <= cmd.t;
      xmem[waddr] <= cmd.x;
      ymem[waddr] <= cmd.y;
      zmem[waddr] <= cmd.z;
    end
    trd <= tmem[raddr];
    xrd <= xmem[raddr];
    yrd <= ymem[raddr];
    zrd <= zmem[raddr];
  end

  // read address follows the scan index
  assign raddr = idx[AW-1:0];

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      idx <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          idx <= '0;
          if (cmd_valid && cmd.op == OP_SAMPLE) begin
            st <= $signed(cmd.t);
            nkeys <= n_raw;
            state <= S_RD0;
          end
        end
        S_RD0: state <= S_CHK0;
        S_CHK0: begin
          // first key or before it
          if (nkeys == (AW+1)'(1) || st <= $signed(trd)) begin
            out_x <= xrd; out_y <= yrd; out_z <= zrd;
            out_valid <= 1'b1;
            state <= S_OUT;
          end else begin
            t0 <= $signed(trd);
            ax <= xrd; ay <= yrd; az <= zrd;
            idx <= (AW+1)'(1);
            state <= S_RDA;
          end
        end
        S_RDA: state <= S_CHKA;
        S_CHKA: begin
          // segment (idx-1, idx)
          if (t0 <= st && st <= $signed(trd)) begin
            if (t0 == $signed(trd)) begin
              out_x <= ax; out_y <= ay; out_z <= az;
              out_valid <= 1'b1;
              state <= S_OUT;
            end else if (st == $signed(trd)) begin
              out_x <= xrd; out_y <= yrd; out_z <= zrd;
              out_valid <= 1'b1;
              state <= S_OUT;
            end else begin
              num <= {st[TW-1], st} - {t0[TW-1], t0};
              den <= {trd[TW-1], trd} - {t0[TW-1], t0};
              rem <= '0;
              dcnt <= 5'd0;
              dx <= {xrd[TW-1], xrd} - {ax[TW-1], ax};
              dy <= {yrd[TW-1], yrd} - {ay[TW-1], ay};
              dz <= {zrd[TW-1], zrd} - {az[TW-1], az};
              state <= S_DIV;
            end
          end else if (idx + (AW+1)'(1) >= nkeys) begin
            out_x <= xrd; out_y <= yrd; out_z <= zrd;
            out_valid <= 1'b1;
            state <= S_OUT;
          end else begin
            t0 <= $signed(trd);
            ax <= xrd; ay <= yrd; az <= zrd;
            idx <= idx + (AW+1)'(1);
            state <= S_RDA;
          end
        end
        S_DIV: begin
          // restoring division of num*2^16 by den, one quotient bit a cycle
          if (dcnt == 5'd0) begin
            rem <= {16'd0, num};
            frac <= '0;
            dcnt <= 5'd1;
          end else begin
            if ({rem[TW+15:0], 1'b0} >= {16'd0, den}) begin
              rem <= {rem[TW+15:0], 1'b0} - {16'd0, den};
              frac <= {frac[14:0], 1'b1};
            end else begin
              rem <= {rem[TW+15:0], 1'b0};
              frac <= {frac[14:0], 1'b0};
            end
            if (dcnt == 5'd16) begin
              mstep <= 2'd0;
              state <= S_MUL;
            end else dcnt <= dcnt + 5'd1;
          end
        end
        S_MUL: begin
          // one product per cycle
          case (mstep)
            2'd0: px <= dx * $signed({2'b00, frac});
            2'd1: py <= dy * $signed({2'b00, frac});
            default: pz <= dz * $signed({2'b00, frac});
          endcase
          if (mstep == 2'd2) state <= S_ADD;
          else mstep <= mstep + 2'd1;
        end
        S_ADD: begin
          out_x <= ax + px[TW+15:16];
          out_y <= ay + py[TW+15:16];
          out_z <= az + pz[TW+15:16];
          out_valid <= 1'b1;
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_valid_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> state == S_OUT) else $error("valid outside output state");
  a_idx: assert property (@(posedge clk) disable iff (rst)
    state == S_CHKA |-> idx < nkeys) else $error("scan past last key");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> !cmd_ready) else $error("accepted while dividing");
`endif
endmodule
`default_nettype wire

@@ rtl/keyframe_track_sampler_core.sv @@
// top level of the keyframe track sampler
//
// Input channel (in_valid/in_ready) carries one item per transfer: opcode 0
// writes a keyframe at key_slot, opcode 1 samples the track at sample_time.
// Output channel (out_valid/out_ready) gives one transfer of out_x/y/z per
// sample item; write items give none.
// keys_in_use is written through cfg_we/cfg_wdata; the user writes it only
// while the block is idle; nothing in the block enforces this. A two-entry
// queue sits in front of the engine, so the input side keeps taking items
// while a result waits for the receiver. A write item is stored in the idle
// state. A sample reads the first key, then scans segments one key read at a
// time and, if it interpolates, runs the one-bit-a-cycle fraction divider
// and the multiply/add, bound by the single read port of the key store.
// A stalled receiver holds the result; the engine waits, the queue fills.
// Reset (rst, synchronous) empties the queue, drops a pending result and
// sets keys_in_use to 1; stored keys are undefined until written.
`default_nettype none
module keyframe_track_sampler_core #(
  parameter int unsigned MAX_KEYS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [6:0]  cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        opcode,
  input  wire logic [5:0]  key_slot,
  input  wire logic [31:0] key_time,
  input  wire logic [31:0] key_x,
  input  wire logic [31:0] key_y,
  input  wire logic [31:0] key_z,
  input  wire logic [31:0] sample_time,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_x,
  output logic [31:0]      out_y,
  output logic [31:0]      out_z
);
  import kts_pkg::*;

  logic [CNT_W-1:0] keys_in_use;
  kts_cmd_t in_cmd;
  kts_cmd_t cmd;
  logic     cmd_valid;
  logic     cmd_ready;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) keys_in_use <= CNT_W'(1);
    else if (cfg_we) keys_in_use <= cfg_wdata;
  end

  // pack the item; one time field serves both opcodes
  always_comb begin
    in_cmd.op   = opcode;
    in_cmd.slot = key_slot;
    in_cmd.t    = (opcode == OP_SAMPLE) ? sample_time : key_time;
    in_cmd.x    = key_x;
    in_cmd.y    = key_y;
    in_cmd.z    = key_z;
  end

  kts_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_cmd(in_cmd),
    .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd)
  );

  kts_back #(.MAX_KEYS(MAX_KEYS)) u_back (
    .clk(clk), .rst(rst), .keys_in_use(keys_in_use),
    .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_x(out_x), .out_y(out_y), .out_z(out_z)
  );
endmodule
`default_nettype wire
